// ----- hw/rtl/lkfr_pkg.sv -----
package lkfr_pkg;

  localparam int TS_W      = 48;
  localparam int FRAME_W   = 6;
  localparam int CNT_OUT_W = 7;
  localparam int K_CFG_W   = 3;
  localparam int K_RESET   = 2;
  localparam int N_FRAMES  = 64;

  typedef logic [1:0] op_t;

  localparam op_t OP_ACCESS = 2'd0;
  localparam op_t OP_SETEV  = 2'd1;
  localparam op_t OP_EVICT  = 2'd2;
  localparam op_t OP_REMOVE = 2'd3;

  typedef logic [TS_W-1:0] ts_t;

endpackage

// ----- hw/rtl/lru_k_frame_replacer_core.sv -----
// Channel  | Ports                                          | Transfer
// ---------+------------------------------------------------+----------------------------
// input    | in_operation, in_frame, in_evictable_flag     | start high, busy low
// result   | out_victim_valid, out_victim_frame,            | out_strobe high, one cycle
//          | out_evictable_count                            |
// config   | cfg_k_depth                                    | cfg_we high
//
// Record access, set evictable and remove do one read of the frame's metadata and history
// memories, then the write back, after which the strobe is raised.
// Evict scans the memories, reading one frame per cycle, and keeps the best candidate
// of both passes at once.
// Reset (synchronous) clears the per-frame valid bits, timestamp and evictable total;
// history memory content is not cleared. The receiver cannot stall results.
module lru_k_frame_replacer_core #(
  parameter int K_MAX      = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  lkfr_pkg::op_t                     in_operation,
  input  logic [lkfr_pkg::FRAME_W-1:0]      in_frame,
  input  logic                              in_evictable_flag,
  output logic                              out_strobe,
  output logic                              out_victim_valid,
  output logic [lkfr_pkg::FRAME_W-1:0]      out_victim_frame,
  output logic [lkfr_pkg::CNT_OUT_W-1:0]    out_evictable_count,
  input  logic                              cfg_we,
  input  logic [lkfr_pkg::K_CFG_W-1:0]      cfg_k_depth
);
  import lkfr_pkg::*;

  localparam int FW  = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
  localparam int KW  = $clog2(K_MAX + 1);
  localparam int HIW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int TW  = $clog2(N_FRAMES + 1);

  typedef logic [FW-1:0] fidx_t;
  typedef logic [KW-1:0] cnt_t;
  typedef struct packed {
    logic mark;
    cnt_t count;
  } meta_t;
  typedef logic [K_MAX-1:0][TS_W-1:0] hist_t;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RMW  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // memories and valid bits
  meta_t meta_mem [N_FRAMES];
  hist_t hist_mem [N_FRAMES];
  logic [N_FRAMES-1:0] vld_r, vld_nxt;
  meta_t meta_q;
  hist_t hist_q;
  logic  vld_q;
  fidx_t rd_addr;
  logic  meta_we, hist_we;
  fidx_t wr_addr;
  meta_t meta_wd;
  hist_t hist_wd;

  logic [1:0] state_r, state_nxt;
  op_t   op_r, op_nxt;
  fidx_t frame_r, frame_nxt;
  logic  flag_r, flag_nxt;
  logic  rng_r, rng_nxt;
  fidx_t ev_r, ev_nxt;
  ts_t   ts_r, ts_nxt;
  logic [TW-1:0] tot_r, tot_nxt;
  logic [K_CFG_W-1:0] kcfg_r;
  cnt_t  keff;

  logic  f1_r, f1_nxt, f2_r, f2_nxt;
  ts_t   b1_r, b1_nxt, b2_r, b2_nxt;
  fidx_t p1_r, p1_nxt, p2_r, p2_nxt;

  logic  strobe_r, strobe_nxt;
  logic  vv_r, vv_nxt;
  fidx_t vf_r, vf_nxt;

  meta_t m;
  cnt_t  c;
  logic  el1, el2;
  ts_t   t1, t2;
  logic  hit;
  fidx_t pick;
  ts_t   ts_inc;

  always_comb begin
    if (kcfg_r == '0) begin
      keff = cnt_t'(1);
    end else if (32'(kcfg_r) > K_MAX) begin
      keff = cnt_t'(K_MAX);
    end else begin
      keff = cnt_t'(kcfg_r);
    end
  end

  always_comb begin
    rd_addr = fidx_t'(in_frame);
    if (state_r == S_SCAN) begin
      rd_addr = ev_r + 1'b1;
    end else if (in_operation == OP_EVICT) begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    meta_q <= meta_mem[rd_addr];
    hist_q <= hist_mem[rd_addr];
    vld_q  <= vld_r[rd_addr];
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wd;
    end
    if (hist_we) begin
      hist_mem[wr_addr] <= hist_wd;
    end
  end

  // untracked entries read as reset value
  assign m   = vld_q ? meta_q : '0;
  assign c   = m.count;
  assign el1 = (c != '0) && m.mark && (c < keff);
  assign el2 = (c != '0) && m.mark && (c >= keff);
  assign t1  = hist_q[HIW'(c - 1'b1)];
  assign t2  = hist_q[HIW'(keff - 1'b1)];
  assign hit = f1_r | f2_r;
  assign pick = f1_r ? p1_r : p2_r;
  assign ts_inc = ts_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    frame_nxt  = frame_r;
    flag_nxt   = flag_r;
    rng_nxt    = rng_r;
    ev_nxt     = ev_r;
    ts_nxt     = ts_r;
    tot_nxt    = tot_r;
    vld_nxt    = vld_r;
    f1_nxt     = f1_r;
    f2_nxt     = f2_r;
    b1_nxt     = b1_r;
    b2_nxt     = b2_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    strobe_nxt = 1'b0;
    vv_nxt     = 1'b0;
    vf_nxt     = '0;
    meta_we    = 1'b0;
    hist_we    = 1'b0;
    wr_addr    = frame_r;
    meta_wd    = m;
    hist_wd    = hist_q;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          frame_nxt = fidx_t'(in_frame);
          flag_nxt  = in_evictable_flag;
          rng_nxt   = 32'(in_frame) < N_FRAMES;
          ev_nxt    = '0;
          f1_nxt    = 1'b0;
          f2_nxt    = 1'b0;
          state_nxt = (in_operation == OP_EVICT) ? S_SCAN : S_RMW;
        end
      end
      S_RMW: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (rng_r) begin
          case (op_r)
            OP_ACCESS: begin
              ts_nxt = ts_inc;
              for (int i = K_MAX - 1; i > 0; i--) begin
                hist_wd[i] = hist_q[i-1];
              end
              hist_wd[0] = ts_inc;
              hist_we    = 1'b1;
              meta_we    = 1'b1;
              if (!vld_q) begin
                meta_wd.mark  = 1'b1;
                meta_wd.count = cnt_t'(1);
                tot_nxt       = tot_r + 1'b1;
                vld_nxt[frame_r] = 1'b1;
              end else if (32'(c) < K_MAX) begin
                meta_wd.count = c + 1'b1;
              end
            end
            OP_SETEV: begin
              if (vld_q) begin
                meta_we      = 1'b1;
                meta_wd.mark = flag_r;
                if (m.mark && !flag_r) begin
                  tot_nxt = tot_r - 1'b1;
                end else if (!m.mark && flag_r) begin
                  tot_nxt = tot_r + 1'b1;
                end
              end
            end
            default: begin
              if (vld_q && m.mark) begin
                vld_nxt[frame_r] = 1'b0;
                tot_nxt          = tot_r - 1'b1;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // strict compare in ascending order: lowest index wins ties
        if (el1 && (!f1_r || t1 < b1_r)) begin
          f1_nxt = 1'b1;
          b1_nxt = t1;
          p1_nxt = ev_r;
        end
        if (el2 && (!f2_r || t2 < b2_r)) begin
          f2_nxt = 1'b1;
          b2_nxt = t2;
          p2_nxt = ev_r;
        end
        ev_nxt = ev_r + 1'b1;
        if (ev_r == fidx_t'(N_FRAMES - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (hit) begin
          vv_nxt        = 1'b1;
          vf_nxt        = pick;
          vld_nxt[pick] = 1'b0;
          tot_nxt       = tot_r - 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vld_r    <= '0;
      ts_r     <= '0;
      tot_r    <= '0;
      kcfg_r   <= K_CFG_W'(K_RESET);
      strobe_r <= 1'b0;
      vv_r     <= 1'b0;
      vf_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      vld_r    <= vld_nxt;
      ts_r     <= ts_nxt;
      tot_r    <= tot_nxt;
      strobe_r <= strobe_nxt;
      vv_r     <= vv_nxt;
      vf_r     <= vf_nxt;
      if (cfg_we) begin
        kcfg_r <= cfg_k_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    frame_r <= frame_nxt;
    flag_r  <= flag_nxt;
    rng_r   <= rng_nxt;
    ev_r    <= ev_nxt;
    f1_r    <= f1_nxt;
    f2_r    <= f2_nxt;
    b1_r    <= b1_nxt;
    b2_r    <= b2_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = strobe_r;
  assign out_victim_valid    = vv_r;
  assign out_victim_frame    = FRAME_W'(vf_r);
  assign out_evictable_count = CNT_OUT_W'(tot_r);

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_RMW || $past(state_r) == S_FIN))
    else $error("result strobe without finishing operation");

  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tot_r) <= N_FRAMES)
    else $error("evictable total exceeds frame count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  a_victim_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_victim_valid |-> (out_strobe && $past(state_r) == S_FIN))
    else $error("victim reported outside evict result");
`endif

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import lkfr_pkg::*;

  localparam int NFR  = N_FRAMES;
  localparam int KMAX = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  op_t                  in_operation = OP_ACCESS;
  logic [FRAME_W-1:0]   in_frame = '0;
  logic                 in_evictable_flag = 1'b0;
  logic                 out_strobe;
  logic                 out_victim_valid;
  logic [FRAME_W-1:0]   out_victim_frame;
  logic [CNT_OUT_W-1:0] out_evictable_count;
  logic                 cfg_we = 1'b0;
  logic [K_CFG_W-1:0]   cfg_k_depth = K_CFG_W'(K_RESET);

  int errors = 0;
  int idle_pct = 0;

  lru_k_frame_replacer_core #(.K_MAX(KMAX)) uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(string what, int got, int exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
  endtask

  typedef struct packed {
    logic                 valid;
    logic [FRAME_W-1:0]   frame;
    logic [CNT_OUT_W-1:0] count;
  } victim_t;

  class lru_k_scoreboard;
    int   hits[NFR];
    ts_t  stamps[NFR][KMAX];
    bit   mark[NFR];
    ts_t  clock_ts;
    int   total;
    int   k_cfg;
    victim_t pending[$];
    int   victims, misses, accepted;

    function new();
      foreach (hits[i]) begin
        hits[i] = 0;
        mark[i] = 0;
      end
      foreach (stamps[a, b]) stamps[a][b] = '0;
      clock_ts = '0;
      total = 0;
      k_cfg = K_RESET;
    endfunction

    function void drop(int f);
      if (mark[f] && hits[f] != 0 && total > 0) total--;
      hits[f] = 0;
      mark[f] = 0;
    endfunction

    function void note(op_t op, int f, bit flag);
      victim_t r;
      int k, pick, c;
      bit found;
      ts_t best;
      r = '0;
      accepted++;
      case (op)
        OP_ACCESS: begin
          clock_ts = clock_ts + 1;
          for (int i = KMAX - 1; i > 0; i--) stamps[f][i] = stamps[f][i-1];
          stamps[f][0] = clock_ts;
          if (hits[f] == 0) begin
            mark[f] = 1;
            total++;
          end
          if (hits[f] < KMAX) hits[f]++;
        end
        OP_SETEV: begin
          if (hits[f] != 0) begin
            if (mark[f] && !flag && total > 0) total--;
            if (!mark[f] && flag) total++;
            mark[f] = flag;
          end
        end
        OP_EVICT: begin
          k = (k_cfg < 1) ? 1 : (k_cfg > KMAX) ? KMAX : k_cfg;
          found = 0;
          best = '0;
          pick = 0;
          // young frames (fewer than K hits) go first, by oldest first access
          for (int i = 0; i < NFR; i++) begin
            c = hits[i];
            if (c == 0 || !mark[i] || c >= k) continue;
            if (!found || stamps[i][c-1] < best) begin
              best = stamps[i][c-1];
              pick = i;
              found = 1;
            end
          end
          if (!found) begin
            for (int i = 0; i < NFR; i++) begin
              c = hits[i];
              if (c == 0 || !mark[i] || c < k) continue;
              if (!found || stamps[i][k-1] < best) begin
                best = stamps[i][k-1];
                pick = i;
                found = 1;
              end
            end
          end
          if (found) begin
            drop(pick);
            r.valid = 1'b1;
            r.frame = FRAME_W'(pick);
            victims++;
          end else misses++;
        end
        default: begin
          if (hits[f] != 0 && mark[f]) drop(f);
        end
      endcase
      r.count = CNT_OUT_W'(total);
      pending.insert(pending.size(), r);
    endfunction

    task check(victim_t got);
      victim_t e;
      if (pending.size() == 0) begin
        report("unexpected result, count", got.count, -1);
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (got.valid !== e.valid) report("victim_valid", got.valid, e.valid);
      if (got.frame !== e.frame) report("victim_frame", got.frame, e.frame);
      if (got.count !== e.count) report("evictable_count", got.count, e.count);
    endtask
  endclass

  lru_k_scoreboard sb = new();

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check({out_victim_valid, out_victim_frame, out_evictable_count});
  end

  task automatic send(op_t op, int f, bit flag);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_operation      <= op;
    in_frame          <= FRAME_W'(f);
    in_evictable_flag <= flag;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note(op, f, flag);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic set_k(int v);
    drain();
    cfg_we      <= 1'b1;
    cfg_k_depth <= K_CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.k_cfg = v;
  endtask

  task automatic random_item(int base);
    op_t op;
    int  r, f;
    r = $urandom_range(0, 99);
    op = (r < 45) ? OP_ACCESS : (r < 60) ? OP_SETEV : (r < 78) ? OP_EVICT : OP_REMOVE;
    // keep most traffic on a small pool so frames build up history
    f = ($urandom_range(0, 99) < 85) ? base + $urandom_range(0, 11) : $urandom_range(0, 63);
    send(op, f, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int kvals[6] = '{1, 4, 0, 7, 3, 2};
    int pcts[4]  = '{0, 77, 0, 15};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default K
    send(OP_ACCESS, 0, 0);
    send(OP_ACCESS, 63, 1);
    send(OP_ACCESS, 0, 0);
    send(OP_SETEV, 63, 0);
    send(OP_SETEV, 5, 1);
    send(OP_EVICT, 0, 0);
    send(OP_REMOVE, 0, 0);
    send(OP_REMOVE, 63, 0);
    send(OP_REMOVE, 7, 1);
    send(OP_EVICT, 0, 0);
    send(OP_ACCESS, 10, 0);
    send(OP_ACCESS, 11, 0);
    send(OP_ACCESS, 10, 0);
    send(OP_EVICT, 0, 0);
    repeat (5) send(OP_ACCESS, 12, 0);
    send(OP_SETEV, 12, 0);
    send(OP_SETEV, 12, 1);
    send(OP_SETEV, 63, 1);
    send(OP_EVICT, 0, 0);
    send(OP_EVICT, 0, 0);
    send(OP_EVICT, 0, 0);

    for (int p = 0; p < 6; p++) begin
      int base;
      set_k(kvals[p]);
      idle_pct = pcts[p % 4];
      base = $urandom_range(0, 52);
      if (p == 3) begin
        // fill every frame, then evict until no evictable frame is left
        for (int f = 0; f < NFR; f++) send(OP_ACCESS, f, 0);
        repeat (NFR + 1) send(OP_EVICT, 0, 0);
      end
      repeat (210) random_item(base);
    end
    drain();
    repeat (NFR + 8) @(posedge clk);

    $display("covered %0d transfers, %0d victims, %0d empty evicts over six K settings",
             sb.accepted, sb.victims, sb.misses);
    $display("%0d mismatches, %0d expectations left", errors, sb.pending.size());
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule
